// ===== sv/mavlink_v2_frame_receiver_assert.svh =====
// Assertion macros shared by the frame receiver modules.
`ifndef MAVLINK_V2_FRAME_RECEIVER_ASSERT_SVH
`define MAVLINK_V2_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MVR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MVR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mvr_pkg.sv =====
// Types, constants and per-byte functions of the frame receiver.
package mvr_pkg;

	localparam logic [7:0]  START_BYTE   = 8'hFD;
	localparam int unsigned HEADER_BYTES = 10;
	localparam int unsigned BUFFER_BYTES = 280;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;

	// header byte offsets, start byte at offset 0
	localparam logic [8:0] HDR_LEN    = 9'd1;
	localparam logic [8:0] HDR_SEQ    = 9'd4;
	localparam logic [8:0] HDR_SYSID  = 9'd5;
	localparam logic [8:0] HDR_COMPID = 9'd6;
	localparam logic [8:0] HDR_ID0    = 9'd7;
	localparam logic [8:0] HDR_ID1    = 9'd8;
	localparam logic [8:0] HDR_ID2    = 9'd9;

	localparam logic [23:0] ID_HEARTBEAT    = 24'd0;
	localparam logic [23:0] ID_VFR_HUD      = 24'd74;
	localparam logic [23:0] ID_COMMAND_LONG = 24'd76;
	localparam logic [23:0] ID_COMMAND_ACK  = 24'd77;

	localparam logic [7:0] EXTRA_HEARTBEAT    = 8'd50;
	localparam logic [7:0] EXTRA_VFR_HUD      = 8'd20;
	localparam logic [7:0] EXTRA_COMMAND_LONG = 8'd152;
	localparam logic [7:0] EXTRA_COMMAND_ACK  = 8'd143;
	localparam logic [7:0] EXTRA_NONE         = 8'd0;

	localparam logic [1:0] CLASS_HEARTBEAT    = 2'd0;
	localparam logic [1:0] CLASS_VFR_HUD      = 2'd1;
	localparam logic [1:0] CLASS_COMMAND_LONG = 2'd2;
	localparam logic [1:0] CLASS_OTHER        = 2'd3;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  index;
		logic [7:0]  data;
		logic [23:0] msg_id;
		logic [1:0]  msg_class;
		logic [7:0]  seq;
		logic [7:0]  sysid;
		logic [7:0]  compid;
		logic [7:0]  length;
		logic        crc_ok;
	} res_t;

	// X.25 (CRC-16/MCRF4XX) update by one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ (t << 4);
		return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
	endfunction

	function automatic logic [7:0] extra_for(input logic [23:0] id);
		logic [7:0] e;
		case (id)
			ID_HEARTBEAT:    e = EXTRA_HEARTBEAT;
			ID_VFR_HUD:      e = EXTRA_VFR_HUD;
			ID_COMMAND_LONG: e = EXTRA_COMMAND_LONG;
			ID_COMMAND_ACK:  e = EXTRA_COMMAND_ACK;
			default:         e = EXTRA_NONE;
		endcase
		return e;
	endfunction

	function automatic logic [1:0] class_for(input logic [23:0] id);
		logic [1:0] c;
		case (id)
			ID_HEARTBEAT:    c = CLASS_HEARTBEAT;
			ID_VFR_HUD:      c = CLASS_VFR_HUD;
			ID_COMMAND_LONG: c = CLASS_COMMAND_LONG;
			default:         c = CLASS_OTHER;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/mavlink_v2_frame_receiver.sv =====
// MAVLink v2 frame receiver top level: input stage, frame core, result buffer.
// Takes one serial byte per beat and accepts a new byte every cycle unless the result
// buffer is full; a byte's result (a payload byte with its index, or the end-of-frame
// status after the second checksum byte) is registered: the byte is held in the input
// register and its result is captured in the result register.
// The per-byte CRC update and header/length decode sit between those two registers.
// A two-entry result buffer keeps input flowing while the output side stalls, until a
// second result is waiting. Frames with a length above max_payload are dropped
// silently; crc_ok = 0 means the payload bytes already sent must be discarded.
module mavlink_v2_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_index,
	output logic [7:0]  payload_data,
	output logic [23:0] message_id,
	output logic [1:0]  message_class,
	output logic [7:0]  sequence_number,
	output logic [7:0]  sender_system,
	output logic [7:0]  sender_component,
	output logic [7:0]  frame_length,
	output logic        crc_ok
);
	import mvr_pkg::*;

	logic [7:0] max_payload_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_valid;
	res_t       res;
	logic       out_valid_q;
	logic       skid_valid_q;
	res_t       out_q;
	res_t       skid_q;
	logic       pop;

	// hold the input byte while the result buffer is full
	assign advance  = valid_s1 && !skid_valid_q;
	assign in_ready = !valid_s1 || advance;
	assign pop      = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= 8'hFF;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	mvr_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= skid_valid_q && res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : res;
			if (skid_valid_q && res_valid) begin
				skid_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = out_q.kind;
	assign payload_index    = out_q.index;
	assign payload_data     = out_q.data;
	assign message_id       = out_q.msg_id;
	assign message_class    = out_q.msg_class;
	assign sequence_number  = out_q.seq;
	assign sender_system    = out_q.sysid;
	assign sender_component = out_q.compid;
	assign frame_length     = out_q.length;
	assign crc_ok           = out_q.crc_ok;

`include "mavlink_v2_frame_receiver_assert.svh"

	`MVR_ASSERT_NOW(a_skid_behind_head, skid_valid_q, out_valid_q,
		"skid entry without head entry")
	`MVR_ASSERT_NOW(a_no_push_when_full, res_valid, !skid_valid_q,
		"result pushed into full buffer")
	`MVR_ASSERT_NEXT(a_skid_drains, skid_valid_q && pop && !res_valid,
		out_valid_q && !skid_valid_q, "skid entry not moved to head")

endmodule

// ===== sv/mvr_core.sv =====
// Frame state machine: header capture, CRC, payload streaming and status.
module mvr_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    max_payload,
	output logic          res_valid,
	output mvr_pkg::res_t res
);
	import mvr_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic [8:0]  byte_count_q, byte_count_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  sysid_q, sysid_d;
	logic [7:0]  compid_q, compid_d;
	logic [23:0] msgid_q, msgid_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_low_q, crc_low_d;

	logic        is_start;
	logic [8:0]  count_inc;
	logic [8:0]  end_low;
	logic [15:0] crc_final;

	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		length_d     = length_q;
		seq_d        = seq_q;
		sysid_d      = sysid_q;
		compid_d     = compid_q;
		msgid_d      = msgid_q;
		crc_d        = crc_q;
		crc_low_d    = crc_low_q;
		res_valid    = 1'b0;
		res          = '0;

		is_start  = (rx_byte == START_BYTE);
		count_inc = byte_count_q + 9'd1;
		end_low   = 9'(HEADER_BYTES) + {1'b0, length_q};
		crc_final = crc_feed(crc_q, extra_for(msgid_q));

		unique case (phase_q)
			PH_HEADER: begin
				crc_d = crc_feed(crc_q, rx_byte);
				unique case (byte_count_q)
					HDR_LEN:    length_d = rx_byte;
					HDR_SEQ:    seq_d    = rx_byte;
					HDR_SYSID:  sysid_d  = rx_byte;
					HDR_COMPID: compid_d = rx_byte;
					HDR_ID0:    msgid_d  = {16'h0000, rx_byte};
					HDR_ID1:    msgid_d  = {8'h00, rx_byte, msgid_q[7:0]};
					HDR_ID2:    msgid_d  = {rx_byte, msgid_q[15:0]};
					default:    ;
				endcase
				byte_count_d = count_inc;
				if (count_inc >= 9'(HEADER_BYTES)) begin
					if (length_q <= max_payload) begin
						phase_d = PH_BODY;
					end else if (is_start) begin
						// resync on a start byte in the last header slot
						phase_d      = PH_HEADER;
						byte_count_d = 9'd1;
						crc_d        = CRC_INIT;
					end else begin
						phase_d      = PH_IDLE;
						byte_count_d = 9'd0;
					end
				end
			end
			PH_BODY: begin
				if (byte_count_q < end_low) begin
					crc_d     = crc_feed(crc_q, rx_byte);
					res_valid = step;
					res.kind  = KIND_PAYLOAD;
					res.index = 8'(byte_count_q - 9'(HEADER_BYTES));
					res.data  = rx_byte;
				end else if (byte_count_q == end_low) begin
					crc_low_d = rx_byte;
				end
				if (byte_count_q > end_low) begin
					res_valid     = step;
					res.kind      = KIND_STATUS;
					res.msg_id    = msgid_q;
					res.msg_class = class_for(msgid_q);
					res.seq       = seq_q;
					res.sysid     = sysid_q;
					res.compid    = compid_q;
					res.length    = length_q;
					res.crc_ok    = ({rx_byte, crc_low_q} == crc_final);
					phase_d       = PH_IDLE;
					byte_count_d  = 9'd0;
				end else begin
					byte_count_d = count_inc;
					// drop the frame on overflow
					if ({1'b0, count_inc} >= 10'(BUFFER_BYTES)) begin
						if (is_start) begin
							phase_d      = PH_HEADER;
							byte_count_d = 9'd1;
							crc_d        = CRC_INIT;
						end else begin
							phase_d      = PH_IDLE;
							byte_count_d = 9'd0;
						end
					end
				end
			end
			default: begin
				if (is_start) begin
					phase_d      = PH_HEADER;
					byte_count_d = 9'd1;
					crc_d        = CRC_INIT;
				end else begin
					phase_d      = PH_IDLE;
					byte_count_d = 9'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			byte_count_q <= 9'd0;
			length_q     <= 8'd0;
			seq_q        <= 8'd0;
			sysid_q      <= 8'd0;
			compid_q     <= 8'd0;
			msgid_q      <= 24'd0;
			crc_q        <= CRC_INIT;
			crc_low_q    <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			length_q     <= length_d;
			seq_q        <= seq_d;
			sysid_q      <= sysid_d;
			compid_q     <= compid_d;
			msgid_q      <= msgid_d;
			crc_q        <= crc_d;
			crc_low_q    <= crc_low_d;
		end
	end

`include "mavlink_v2_frame_receiver_assert.svh"

	`MVR_ASSERT_NOW(a_idle_count_zero, phase_q == PH_IDLE, byte_count_q == 9'd0,
		"count not cleared while hunting")
	`MVR_ASSERT_NOW(a_header_count_range, phase_q == PH_HEADER,
		(byte_count_q >= 9'd1) && (byte_count_q < 9'(HEADER_BYTES)),
		"header count out of range")
	`MVR_ASSERT_NOW(a_result_in_body, res_valid, step && (phase_q == PH_BODY),
		"result outside frame body")

endmodule
